/* design/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants
// Widths, CORDIC tables and the Q30 product rounding used by the whole block.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF  = 20;
  localparam int RESULT_FRAC_BITS_DEF = 28;
  localparam int N_ITER    = 30;
  localparam int SQRT_BITS = 31;

  localparam logic signed [33:0] CORDIC_K_Q30   = 34'sd652032874;
  localparam logic signed [35:0] PI_Q30         = 36'sd3373259426;
  localparam logic signed [35:0] PI_2_Q30       = 36'sd1686629713;
  localparam logic signed [33:0] ONE_Q30        = 34'sd1073741824;
  localparam logic [28:0]        DEG_TO_RAD_Q34 = 29'd299845282;
  localparam logic [23:0]        RECIP_360      = 24'd11930465;  // ceil(2^32/360)

  localparam logic [29:0] ATAN_Q30 [N_ITER] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2
  };

  // rotation lane: x/y are cos/sin accumulators, z residual angle
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } rot_t;

  // square-root lane, carries the operands of the later atan2 stages
  typedef struct packed {
    logic [61:0]        rem;
    logic [61:0]        res;
    logic signed [31:0] cs;
    logic signed [33:0] yv;
    logic signed [33:0] xv;
  } sq_t;

  // vectoring lane
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
  } vec_t;

  // Q30 x Q30 -> Q30, round half up
  function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    p = p + 68'sd536870912;
    return p[63:30];
  endfunction

endpackage

/* design/great_circle_distance_and_angle.sv */
// Throughput: one beat per cycle unless the output stalls. The chain has 30
// rotation, 31 root and 30 vectoring cells, each a single register stage.
// A stalled output holds its beat; the chain keeps filling until its last
// stage is occupied. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
// great_circle_distance_and_angle: sky separation and position angle
// Degree inputs to sin/cos lanes, products, root, two atan2 lanes, rounding.
// ----------------------------------------------------------------------------
module great_circle_distance_and_angle
  import gcd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [27:0] lat_first_i,
  input  logic signed [28:0] lon_first_i,
  input  logic signed [27:0] lat_second_i,
  input  logic signed [28:0] lon_second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [29:0]        separation_o,
  output logic signed [31:0] position_angle_o
);

  localparam int DEPTH = 3 + N_ITER + 3 + SQRT_BITS + 1 + N_ITER;
  localparam int SH    = 30 - RESULT_FRAC_BITS;

  logic             en, out_ld;
  logic [DEPTH-1:0] v_q;
  logic             out_valid_q;

  assign out_ld     = !out_valid_q || !out_stall_i;
  assign en         = out_ld || !v_q[DEPTH-1];
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en)     v_q         <= {v_q[DEPTH-2:0], in_valid_i};
      if (out_ld) out_valid_q <= v_q[DEPTH-1];
    end
  end

  // sin/cos lanes: lat1, lat2, dlon
  logic signed [30:0] deg [3];
  rot_t rot_c [3][N_ITER+1];

  assign deg[0] = 31'(lat_first_i);
  assign deg[1] = 31'(lat_second_i);
  assign deg[2] = 31'(lon_second_i) - 31'(lon_first_i);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    gcd_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red (
      .clk_i, .en_i(en), .deg_i(deg[l]), .q_o(rot_c[l][0])
    );
    for (genvar i = 0; i < N_ITER; i++) begin : g_rot
      gcd_rot_cell #(.IDX(i)) u_cell (
        .clk_i, .en_i(en), .d_i(rot_c[l][i]), .q_o(rot_c[l][i+1])
      );
    end
  end

  // products
  logic signed [33:0] c1, s1, c2, s2, cd, sd;
  logic signed [33:0] p_ss_q, p_cc_q, yv1_q, p_scd_q, p_cs_q, cd_q, c2_q;

  always_comb begin
    c1 = rot_c[0][N_ITER].neg ? -rot_c[0][N_ITER].x : rot_c[0][N_ITER].x;
    s1 = rot_c[0][N_ITER].neg ? -rot_c[0][N_ITER].y : rot_c[0][N_ITER].y;
    c2 = rot_c[1][N_ITER].neg ? -rot_c[1][N_ITER].x : rot_c[1][N_ITER].x;
    s2 = rot_c[1][N_ITER].neg ? -rot_c[1][N_ITER].y : rot_c[1][N_ITER].y;
    cd = rot_c[2][N_ITER].neg ? -rot_c[2][N_ITER].x : rot_c[2][N_ITER].x;
    sd = rot_c[2][N_ITER].neg ? -rot_c[2][N_ITER].y : rot_c[2][N_ITER].y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ss_q  <= mulq(s1, s2);
      p_cc_q  <= mulq(c1, c2);
      yv1_q   <= mulq(sd, c2);
      p_scd_q <= mulq(s1, cd);
      p_cs_q  <= mulq(c1, s2);
      cd_q    <= cd;
      c2_q    <= c2;
    end
  end

  logic signed [33:0] cosd_q, xv2_q, yv2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cosd_q <= p_ss_q + mulq(p_cc_q, cd_q);
      xv2_q  <= mulq(p_scd_q, c2_q) - p_cs_q;
      yv2_q  <= yv1_q;
    end
  end

  // clamp and 1 - c^2
  logic signed [31:0] cl;
  logic signed [63:0] cc;
  sq_t sq_c [SQRT_BITS+1];
  sq_t sq_d;

  always_comb begin
    if (cosd_q > ONE_Q30)       cl = 32'(ONE_Q30);
    else if (cosd_q < -ONE_Q30) cl = 32'(-ONE_Q30);
    else                        cl = 32'(cosd_q);
    cc = cl * cl;
    sq_d.rem = 62'((64'sd1 <<< 60) - cc);
    sq_d.res = '0;
    sq_d.cs  = cl;
    sq_d.yv  = yv2_q;
    sq_d.xv  = xv2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) sq_c[0] <= sq_d;
  end

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    gcd_sqrt_cell #(.K(SQRT_BITS - 1 - j)) u_cell (
      .clk_i, .en_i(en), .d_i(sq_c[j]), .q_o(sq_c[j+1])
    );
  end

  // atan2 lanes: 0 separation, 1 position angle
  vec_t vec_c [2][N_ITER+1];
  vec_t pre_d [2];
  logic signed [35:0] ax [2];
  logic signed [35:0] ay [2];

  assign ay[0] = $signed({1'b0, sq_c[SQRT_BITS].res[34:0]});
  assign ax[0] = 36'(sq_c[SQRT_BITS].cs);
  assign ay[1] = 36'(sq_c[SQRT_BITS].yv);
  assign ax[1] = 36'(sq_c[SQRT_BITS].xv);

  for (genvar l = 0; l < 2; l++) begin : g_atan
    always_comb begin
      pre_d[l].x = ax[l];
      pre_d[l].y = ay[l];
      pre_d[l].z = '0;
      if (ax[l] < 0) begin
        pre_d[l].x = -ax[l];
        pre_d[l].y = -ay[l];
        pre_d[l].z = (ay[l] >= 0) ? PI_Q30 : -PI_Q30;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) vec_c[l][0] <= pre_d[l];
    end

    for (genvar i = 0; i < N_ITER; i++) begin : g_vec
      gcd_vec_cell #(.IDX(i)) u_cell (
        .clk_i, .en_i(en), .d_i(vec_c[l][i]), .q_o(vec_c[l][i+1])
      );
    end
  end

  // rounding to the result format
  logic signed [35:0] sep_r, ang_r, ang_z;

  always_comb begin
    ang_z = vec_c[1][N_ITER].z - PI_2_Q30;
    if (SH > 0) begin
      sep_r = (vec_c[0][N_ITER].z + (36'sd1 <<< (SH - 1))) >>> SH;
      ang_r = (ang_z + (36'sd1 <<< (SH - 1))) >>> SH;
    end else begin
      sep_r = vec_c[0][N_ITER].z;
      ang_r = ang_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      separation_o     <= sep_r[29:0];
      position_angle_o <= ang_r[31:0];
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && v_q[DEPTH-1]))
    else $error("input stalled without a blocked output beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(separation_o)))
    else $error("output beat changed under stall");

  a_sep_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !vec_c[0][N_ITER].z[35] || !v_q[DEPTH-1])
    else $error("negative separation angle");
`endif

endmodule

/* design/gcd_reduce.sv */
// ----------------------------------------------------------------------------
// gcd_reduce: degree wrap and conversion to radians
// Three stages: turn count by reciprocal, wrap/fold to +-90, scale to Q30.
// ----------------------------------------------------------------------------
module gcd_reduce
  import gcd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [30:0] deg_i,
  output rot_t               q_o
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int WR    = F + 10;
  localparam int BIAS_T = ((1 << (31 - F)) + 359) / 360 + 1;  // bias in turns
  localparam logic signed [40:0] FULL    = 41'sd360 <<< F;
  localparam logic signed [40:0] HALF    = 41'sd180 <<< F;
  localparam logic signed [40:0] QUARTER = 41'sd90 <<< F;
  localparam logic [19:0] BIAS_DEG = 20'(BIAS_T * 360);
  localparam logic [63:0] RND = 64'd1 << (F + 3);

  // stage 1
  logic signed [30:0] d_s;
  logic [19:0]        d_u;
  logic [43:0]        dq;
  logic [11:0]        turns_d, turns_q;
  logic signed [30:0] deg_q;

  assign d_s     = deg_i >>> F;
  assign d_u     = 20'(d_s) + BIAS_DEG;
  assign dq      = d_u * RECIP_360;
  assign turns_d = dq[43:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      turns_q <= turns_d;
      deg_q   <= deg_i;
    end
  end

  // stage 2
  logic signed [40:0]   tq, r0, r1, r2;
  logic                 neg_d, neg_q;
  logic signed [WR-1:0] r_q;

  always_comb begin
    tq = $signed({29'd0, turns_q}) - 41'(BIAS_T);
    r0 = 41'(deg_q) - tq * FULL;
    r1 = (r0 >= HALF) ? r0 - FULL : r0;
    neg_d = 1'b0;
    r2 = r1;
    if (r1 > QUARTER) begin
      r2 = r1 - HALF;
      neg_d = 1'b1;
    end else if (r1 < -QUARTER) begin
      r2 = r1 + HALF;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= r2[WR-1:0];
      neg_q <= neg_d;
    end
  end

  // stage 3
  logic [WR-1:0] mag;
  logic [63:0]   pr;
  logic [33:0]   zm;
  rot_t          q_d, q_q;

  always_comb begin
    mag = r_q[WR-1] ? WR'(-r_q) : WR'(r_q);
    pr  = 64'(mag) * 64'(DEG_TO_RAD_Q34);
    pr  = (pr + RND) >> (F + 4);
    zm  = pr[33:0];
    q_d.x   = CORDIC_K_Q30;
    q_d.y   = '0;
    q_d.z   = r_q[WR-1] ? -$signed(zm) : $signed(zm);
    q_d.neg = neg_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

/* design/gcd_rot_cell.sv */
// ----------------------------------------------------------------------------
// gcd_rot_cell: one rotation CORDIC step
// Rotates toward zero residual angle by atan(2^-IDX).
// ----------------------------------------------------------------------------
module gcd_rot_cell
  import gcd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  rot_t d_i,
  output rot_t q_o
);

  rot_t q_d, q_q;
  logic signed [33:0] xs, ys;

  always_comb begin
    xs  = d_i.y >>> IDX;
    ys  = d_i.x >>> IDX;
    q_d = d_i;
    if (!d_i.z[33]) begin
      q_d.x = d_i.x - xs;
      q_d.y = d_i.y + ys;
      q_d.z = d_i.z - 34'(ATAN_Q30[IDX]);
    end else begin
      q_d.x = d_i.x + xs;
      q_d.y = d_i.y - ys;
      q_d.z = d_i.z + 34'(ATAN_Q30[IDX]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

/* design/gcd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// gcd_sqrt_cell: one digit of the integer square root
// Tests bit 4^K against the remainder, passes the atan2 operands along.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell
  import gcd_pkg::*;
#(
  parameter int K = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  d_i,
  output sq_t  q_o
);

  localparam logic [61:0] BIT = 62'd1 << (2 * K);

  sq_t q_d, q_q;
  logic [61:0] t;

  always_comb begin
    t   = d_i.res + BIT;
    q_d = d_i;
    if (d_i.rem >= t) begin
      q_d.rem = d_i.rem - t;
      q_d.res = (d_i.res >> 1) + BIT;
    end else begin
      q_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

/* design/gcd_vec_cell.sv */
// ----------------------------------------------------------------------------
// gcd_vec_cell: one vectoring CORDIC step
// Drives y toward zero, accumulating the angle; y of zero holds.
// ----------------------------------------------------------------------------
module gcd_vec_cell
  import gcd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t d_i,
  output vec_t q_o
);

  vec_t q_d, q_q;
  logic signed [35:0] xs, ys;

  always_comb begin
    xs  = d_i.y >>> IDX;
    ys  = d_i.x >>> IDX;
    q_d = d_i;
    if (d_i.y > 0) begin
      q_d.x = d_i.x + xs;
      q_d.y = d_i.y - ys;
      q_d.z = d_i.z + 36'(ATAN_Q30[IDX]);
    end else if (d_i.y < 0) begin
      q_d.x = d_i.x - xs;
      q_d.y = d_i.y + ys;
      q_d.z = d_i.z - 36'(ATAN_Q30[IDX]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

/* tb/sv/great_circle_distance_and_angle_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_distance_and_angle_checker: scoreboard for the sky-distance block
// Watches both channels, computes the expected separation and position angle
// of each accepted input beat and compares them with the output beats in order.
// ----------------------------------------------------------------------------
module great_circle_distance_and_angle_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [27:0] lat_first_i,
  input  logic signed [28:0] lon_first_i,
  input  logic signed [27:0] lat_second_i,
  input  logic signed [28:0] lon_second_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [29:0]        separation_i,
  input  logic signed [31:0] position_angle_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import gcd_pkg::*;

  localparam int AFB = ANGLE_FRAC_BITS_DEF;
  localparam int RFB = RESULT_FRAC_BITS_DEF;

  typedef struct {
    logic [29:0]        sep;
    logic signed [31:0] pa;
  } sky_result_t;

  sky_result_t expected_q[$];
  longint atan_tab[N_ITER];

  initial begin
    for (int i = 0; i < N_ITER; i++) atan_tab[i] = longint'(ATAN_Q30[i]);
  end

  assign pending_o = expected_q.size();

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  // rotation CORDIC on a degree angle; quadrant folding negates both outputs
  function automatic void sincos_deg(input longint deg, output longint c,
                                     output longint s);
    longint full, half, quarter, r, x, y, z, xs, ys, mag, q;
    bit flip;
    full = longint'(360) << AFB;
    half = longint'(180) << AFB;
    quarter = longint'(90) << AFB;
    r = deg % full;
    flip = 0;
    if (r < 0) r += full;
    if (r >= half) r -= full;
    if (r > quarter) begin
      r -= half;
      flip = 1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1;
    end
    mag = r < 0 ? -r : r;
    q = (mag * longint'(DEG_TO_RAD_Q34) + (longint'(1) << (AFB + 3))) >> (AFB + 4);
    z = r < 0 ? -q : q;
    x = longint'(CORDIC_K_Q30);
    y = 0;
    for (int i = 0; i < N_ITER; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (z >= 0) begin
        x -= xs; y += ys; z -= atan_tab[i];
      end else begin
        x += xs; y -= ys; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_ITER; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y > 0) begin
        x += xs; y -= ys; z += atan_tab[i];
      end else if (y < 0) begin
        x -= xs; y += ys; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic sky_result_t predict_sky(longint lat1, longint lon1,
                                              longint lat2, longint lon2);
    longint c1, s1, c2, s2, cd, sd, cosd, root, sep, ang, yv, xv;
    sky_result_t r;
    sincos_deg(lat1, c1, s1);
    sincos_deg(lat2, c2, s2);
    sincos_deg(lon2 - lon1, cd, sd);
    cosd = prod_q30(s1, s2) + prod_q30(prod_q30(c1, c2), cd);
    if (cosd > longint'(ONE_Q30)) cosd = longint'(ONE_Q30);
    if (cosd < -longint'(ONE_Q30)) cosd = -longint'(ONE_Q30);
    root = floor_sqrt(longint'((longint'(1) << 60) - cosd * cosd));
    sep = vec_atan2(root, cosd);
    yv = prod_q30(sd, c2);
    xv = prod_q30(prod_q30(s1, cd), c2) - prod_q30(c1, s2);
    ang = vec_atan2(yv, xv) - longint'(PI_2_Q30);
    r.sep = 30'(round_shift(sep, 30 - RFB));
    r.pa = 32'(round_shift(ang, 30 - RFB));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    sky_result_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_sky(lat_first_i, lon_first_i,
                                         lat_second_i, lon_second_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("output beat with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (separation_i !== e.sep)
            report_mismatch($sformatf("separation got %0d want %0d",
                                      separation_i, e.sep));
          if (position_angle_i !== e.pa)
            report_mismatch($sformatf("position_angle got %0d want %0d",
                                      position_angle_i, e.pa));
        end
      end
    end
  end
endmodule

/* tb/sv/great_circle_distance_and_angle_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_distance_and_angle_tb: top of the sky-distance testbench
// Drives directed corner pairs then random pairs with random gaps and output
// stalls, including a long stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module great_circle_distance_and_angle_tb;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;
  localparam int N_RANDOM = 950;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [27:0] lat_first_i;
  logic signed [28:0] lon_first_i;
  logic signed [27:0] lat_second_i;
  logic signed [28:0] lon_second_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [29:0]        separation_o;
  logic signed [31:0] position_angle_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;
  bit                 long_hold_done;

  great_circle_distance_and_angle uut (.*);

  great_circle_distance_and_angle_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .lat_first_i, .lon_first_i, .lat_second_i, .lon_second_i,
    .out_valid_i(out_valid_o), .out_stall_i, .separation_i(separation_o),
    .position_angle_i(position_angle_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // receiver: random stalls, plus one long hold while the sender keeps going
  initial begin
    int n;
    out_stall_i = 0;
    long_hold_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && cycle_count > 300) begin
        out_stall_i <= 1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 0;
        long_hold_done = 1;
      end else if (cycle_count % 2000 < 600) begin
        out_stall_i <= 0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall_i <= 1;
          repeat (n - 1) @(negedge clk_i);
        end else begin
          out_stall_i <= 0;
        end
      end
    end
  end

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  task automatic send_pair(input longint a, input longint b, input longint c,
                           input longint d);
    int g;
    g = (cycle_count % 2000 < 600) ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i   <= 1;
    lat_first_i  <= 28'(a);
    lon_first_i  <= 29'(b);
    lat_second_i <= 28'(c);
    lon_second_i <= 29'(d);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    longint q90, q180;
    int kind;
    q90 = longint'(90) << 20;
    q180 = longint'(180) << 20;
    rst_ni = 0;
    in_valid_i = 0;
    lat_first_i = 0;
    lon_first_i = 0;
    lat_second_i = 0;
    lon_second_i = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed corners
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(0, 0, 0, q180);
    send_pair(0, q180, 0, -q180);
    send_pair(10 << 20, 0, q90, 0);
    send_pair(-(20 << 20), 5 << 20, -q90, 30 << 20);
    send_pair(q90, 0, q90, 0);
    send_pair(-q90, 0, q90, 0);
    send_pair(0, 0, 0, 1);
    send_pair(12345, 678, 12345, 678);
    send_pair(q90 + 1, 0, q90 + 1, q90);
    send_pair(-(28'sh8000000), -(29'sh10000000), 28'sh7FFFFFF, 29'shFFFFFFF);
    send_pair(28'sh7FFFFFF, 29'shFFFFFFF, -(28'sh8000000), -(29'sh10000000));
    send_pair(-1, -1, -1, -1);
    send_pair(30 << 20, 0, -(30 << 20), 179 << 20);
    send_pair(45 << 20, 90 << 20, 45 << 20, -(90 << 20));
    send_pair(LAT_MAX, 0, LAT_MAX, q180);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9);
      if (kind < 7)
        send_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
                  rand_span(LAT_MAX), rand_span(LON_MAX));
      else if (kind < 9)
        send_pair($urandom, $urandom, $urandom, $urandom);
      else
        send_pair(rand_span(LAT_MAX), 0, rand_span(LAT_MAX), $urandom_range(64));
    end
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
